// ----- rtl/h4d_pkg.sv -----
// Shared constants and types for the H4 packet deframer.
// No dependencies; the parser, the top and the testbench use it by scoped names.
`default_nettype none

package h4d_pkg;

  // Packet type bytes on the link
  localparam logic [7:0] TYPE_EVENT = 8'h04;
  localparam logic [7:0] TYPE_ACL   = 8'h02;

  // Header sizes in bytes, type byte excluded
  localparam logic [2:0] EVT_HDR = 3'd2;
  localparam logic [2:0] ACL_HDR = 3'd4;

  // Most results one received byte can cause (full ACL header)
  localparam logic [2:0] MAX_RES = 3'd4;

  localparam logic [15:0] MAX_PKT_RESET = 16'd1024;

  // Result status codes
  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_BAD_TYP = 2'd1;
  localparam logic [1:0] ST_TOO_LNG = 2'd2;

  // Group of results produced by one received byte
  typedef struct packed {
    logic            kind;
    logic [1:0]      status;
    logic [2:0]      count;   // 0..MAX_RES results
    logic            first;   // entry 0 opens a packet
    logic            last;    // final entry closes a packet
    logic [3:0][7:0] data;
  } grp_t;

endpackage

`default_nettype wire

// ----- rtl/h4d_in_if.sv -----
// Receive byte channel: valid/ready handshake with one byte of payload.
// Depends on nothing.
`default_nettype none

interface h4d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/h4d_out_if.sv -----
// Result channel: valid/ready handshake carrying one deframed result.
// Depends on nothing.
`default_nettype none

interface h4d_out_if;
  logic       valid;
  logic       ready;
  logic       packet_kind;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic [1:0] status;
  logic       run_end;

  modport source (output valid, output packet_kind, output data_byte, output first_byte,
                  output last_byte, output status, output run_end, input ready);
  modport sink   (input valid, input packet_kind, input data_byte, input first_byte,
                  input last_byte, input status, input run_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/h4d_parser.sv -----
// H4 framing state machine: consumes one byte per accepted transaction and
// builds the group of results it causes. Depends on h4d_pkg.
`default_nettype none

module h4d_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        take_i,      // byte accepted this cycle
  input  wire logic [7:0]  byte_i,
  input  wire logic [15:0] max_pkt_i,
  output h4d_pkg::grp_t    grp_o
);

  localparam logic [1:0] PH_TYPE    = 2'd0;
  localparam logic [1:0] PH_EVT     = 2'd1;
  localparam logic [1:0] PH_ACL     = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [15:0] rem_q, rem_d;
  logic        acl_q, acl_d;
  logic [7:0]  hdr_q [3];

  logic [1:0]  hdr_last;   // header bytes held before the final one
  logic [2:0]  hdr_size;
  logic [15:0] len;
  logic [16:0] total;
  logic        hdr_wr;

  always_comb begin
    hdr_last = acl_q ? 2'(h4d_pkg::ACL_HDR - 3'd1) : 2'(h4d_pkg::EVT_HDR - 3'd1);
    hdr_size = acl_q ? h4d_pkg::ACL_HDR : h4d_pkg::EVT_HDR;
    len      = acl_q ? {byte_i, hdr_q[2]} : {8'h00, byte_i};
    total    = {1'b0, len} + {14'd0, hdr_size};
  end

  always_comb begin
    phase_d = phase_q;
    hcnt_d  = hcnt_q;
    rem_d   = rem_q;
    acl_d   = acl_q;
    hdr_wr  = 1'b0;
    grp_o   = '0;
    grp_o.kind   = acl_q;
    grp_o.status = h4d_pkg::ST_DATA;
    unique case (phase_q)
      PH_TYPE: begin
        if (byte_i == h4d_pkg::TYPE_EVENT) begin
          acl_d   = 1'b0;
          phase_d = PH_EVT;
          hcnt_d  = 2'd0;
        end else if (byte_i == h4d_pkg::TYPE_ACL) begin
          acl_d   = 1'b1;
          phase_d = PH_ACL;
          hcnt_d  = 2'd0;
        end else begin
          grp_o.kind    = 1'b0;
          grp_o.status  = h4d_pkg::ST_BAD_TYP;
          grp_o.count   = 3'd1;
          grp_o.data[0] = byte_i;
        end
      end
      PH_EVT, PH_ACL: begin
        if (hcnt_q < hdr_last) begin
          hdr_wr = 1'b1;
          hcnt_d = hcnt_q + 2'd1;
        end else begin
          hcnt_d = 2'd0;
          if (total > {1'b0, max_pkt_i}) begin
            grp_o.status  = h4d_pkg::ST_TOO_LNG;
            grp_o.count   = 3'd1;
            grp_o.data[0] = byte_i;
            phase_d       = PH_TYPE;
          end else begin
            grp_o.first = 1'b1;
            grp_o.last  = (len == 16'd0);
            if (acl_q) begin
              grp_o.count = h4d_pkg::ACL_HDR;
              grp_o.data  = {byte_i, hdr_q[2], hdr_q[1], hdr_q[0]};
            end else begin
              grp_o.count   = h4d_pkg::EVT_HDR;
              grp_o.data[0] = hdr_q[0];
              grp_o.data[1] = byte_i;
            end
            if (len == 16'd0) begin
              phase_d = PH_TYPE;
            end else begin
              rem_d   = len;
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        grp_o.count   = 3'd1;
        grp_o.data[0] = byte_i;
        grp_o.last    = (rem_q <= 16'd1);
        if (rem_q <= 16'd1) begin
          rem_d   = 16'd0;
          phase_d = PH_TYPE;
        end else begin
          rem_d = rem_q - 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      hcnt_q  <= 2'd0;
      rem_q   <= 16'd0;
      acl_q   <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      rem_q   <= rem_d;
      acl_q   <= acl_d;
    end
  end

  // Header bytes: no reset, always written before read
  always_ff @(posedge clk_i) begin
    if (take_i && hdr_wr) begin
      if (hcnt_q == 2'd0) hdr_q[0] <= byte_i;
      if (hcnt_q == 2'd1) hdr_q[1] <= byte_i;
      if (hcnt_q == 2'd2) hdr_q[2] <= byte_i;
    end
  end

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (rem_q != 16'd0))
    else $error("payload phase with nothing remaining");

  // event header holds at most one byte before its length byte
  a_evt_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EVT) |-> (!acl_q && hcnt_q <= 2'd1))
    else $error("event header state inconsistent");

  a_acl_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ACL) |-> acl_q)
    else $error("ACL header state inconsistent");

endmodule

`default_nettype wire

// ----- rtl/h4_packet_deframer.sv -----
// H4 packet deframer top: config register, parser and result buffer.
// Latency: a result appears the cycle after the byte that causes it is taken.
// Throughput with res_o.ready high: one byte per cycle while each byte yields
// at most one result; a completed header yields 2 (event) or 4 (ACL) results,
// one per cycle, and the next byte is taken in the cycle the last one drains.
// Reset (rst_ni, async, active low): waits for a type byte, buffer empty,
// max_packet_size = 1024. No clearing pass.
`default_nettype none

module h4_packet_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  h4d_in_if.sink           rx_i,
  h4d_out_if.source        res_o
);

  logic [15:0]     max_pkt_q;

  h4d_pkg::grp_t   grp;
  logic            take;
  logic            pop;

  // Result buffer: holds the group of the last byte taken
  logic [2:0]      cnt_q;     // results still to deliver
  logic [1:0]      rd_q;      // entry being offered
  logic            kind_q;
  logic [1:0]      status_q;
  logic            first_q;
  logic            last_q;
  logic [3:0][7:0] data_q;

  // Configuration register, written only while idle by the user (unenforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkt_q <= h4d_pkg::MAX_PKT_RESET;
    end else if (cfg_we_i) begin
      max_pkt_q <= cfg_wdata_i;
    end
  end

  // A new byte is taken when the buffer is empty or its final result
  // leaves in this same cycle; header bursts and a stalled sink hold rx back.
  assign pop        = res_o.valid && res_o.ready;
  assign rx_i.ready = (cnt_q == 3'd0) || (pop && cnt_q == 3'd1);
  assign take       = rx_i.valid && rx_i.ready;

  h4d_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .byte_i    (rx_i.rx_byte),
    .max_pkt_i (max_pkt_q),
    .grp_o     (grp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      rd_q  <= 2'd0;
    end else if (take) begin
      // buffer is free here; a held header byte leaves it empty
      cnt_q <= grp.count;
      rd_q  <= 2'd0;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
      rd_q  <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q   <= grp.kind;
      status_q <= grp.status;
      first_q  <= grp.first;
      last_q   <= grp.last;
      data_q   <= grp.data;
    end
  end

  // Result channel
  assign res_o.valid       = (cnt_q != 3'd0);
  assign res_o.packet_kind = kind_q;
  assign res_o.data_byte   = data_q[rd_q];
  assign res_o.first_byte  = first_q && (rd_q == 2'd0);
  assign res_o.last_byte   = last_q && (cnt_q == 3'd1);
  assign res_o.status      = status_q;
  assign res_o.run_end     = (cnt_q == 3'd1);

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, rd_q} + cnt_q) <= h4d_pkg::MAX_RES)
    else $error("result buffer index past group end");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q > 3'd1) |=> (res_o.valid && rd_q == $past(rd_q) + 2'd1))
    else $error("header burst broken");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.last_byte) |-> res_o.run_end)
    else $error("packet end without run end");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != h4d_pkg::ST_DATA) |->
      (cnt_q == 3'd1 && rd_q == 2'd0 && !res_o.first_byte && !res_o.last_byte))
    else $error("error result not alone");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for h4_packet_deframer: directed table, then random H4 traffic.
// Depends on h4d_pkg, h4d_in_if, h4d_out_if and the h4_packet_deframer RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned CYCLE_LIMIT    = 200_000;
  localparam int unsigned N_PHASES       = 6;
  localparam int unsigned RAND_PER_PHASE = 18;

  // Parser position, mirrors the block's own phases
  typedef enum logic [1:0] {WAIT_TYPE, EVT_HEADER, ACL_HEADER, PAYLOAD} parse_phase_e;

  // How a directed row is used: register write, byte with no result,
  // byte with one result typed in the table, byte checked by the predictor
  typedef enum logic [1:0] {ROW_CFG, ROW_NONE, ROW_ONE, ROW_PRED} row_kind_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [1:0] status;
    logic       run_end;
  } h4_result_t;

  typedef struct packed {
    row_kind_e   how;
    logic [15:0] val;   // rx byte in [7:0], or max_packet_size for ROW_CFG
    h4_result_t  res;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;

  h4d_in_if  rx_if ();
  h4d_out_if res_if ();

  h4_packet_deframer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Directed table. Typed results are the ones readable at a glance: bad type
  // bytes and over-length drops. Header and payload rows go to the predictor.
  // ---------------------------------------------------------------------------
  dir_row_t dir_tbl [24] = '{
    // bad type bytes at both extremes, register at its reset value
    '{ROW_ONE,  16'h0000, '{1'b0, 8'h00, 1'b0, 1'b0, h4d_pkg::ST_BAD_TYP, 1'b1}},
    '{ROW_ONE,  16'h00FF, '{1'b0, 8'hFF, 1'b0, 1'b0, h4d_pkg::ST_BAD_TYP, 1'b1}},
    // event, two payload bytes
    '{ROW_NONE, 16'h0004, '0},
    '{ROW_NONE, 16'h003E, '0},
    '{ROW_PRED, 16'h0002, '0},
    '{ROW_PRED, 16'h00AA, '0},
    '{ROW_PRED, 16'h0055, '0},
    // event with zero length: header is the whole packet
    '{ROW_NONE, 16'h0004, '0},
    '{ROW_NONE, 16'h000F, '0},
    '{ROW_PRED, 16'h0000, '0},
    // ACL, all ones header: length 0xFFFF is far over 1024
    '{ROW_NONE, 16'h0002, '0},
    '{ROW_NONE, 16'h00FF, '0},
    '{ROW_NONE, 16'h00FF, '0},
    '{ROW_NONE, 16'h00FF, '0},
    '{ROW_ONE,  16'h00FF, '{1'b1, 8'hFF, 1'b0, 1'b0, h4d_pkg::ST_TOO_LNG, 1'b1}},
    // smallest buffer: an empty ACL packet still fits
    '{ROW_CFG,  16'd4,    '0},
    '{ROW_NONE, 16'h0002, '0},
    '{ROW_NONE, 16'h0000, '0},
    '{ROW_NONE, 16'h0000, '0},
    '{ROW_NONE, 16'h0000, '0},
    '{ROW_PRED, 16'h0000, '0},
    // event header 2 + length 3 > 4
    '{ROW_NONE, 16'h0004, '0},
    '{ROW_NONE, 16'h0001, '0},
    '{ROW_ONE,  16'h0003, '{1'b0, 8'h03, 1'b0, 1'b0, h4d_pkg::ST_TOO_LNG, 1'b1}}
  };

  // ---------------------------------------------------------------------------
  // Predictor state
  // ---------------------------------------------------------------------------
  parse_phase_e prs_phase    = WAIT_TYPE;
  logic [7:0]   hdr_bytes [3];
  int unsigned  hdr_held     = 0;
  int unsigned  payload_left = 0;
  logic         cur_acl      = 1'b0;
  logic [15:0]  max_pkt_size = h4d_pkg::MAX_PKT_RESET;

  h4_result_t step_results [$];   // results of the byte just taken
  h4_result_t deframed_q   [$];   // results still owed by the block

  bit          idle_en = 1'b1;
  int unsigned bytes_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned bad_type_seen = 0;
  int unsigned too_long_seen = 0;
  int unsigned pkts_closed = 0;
  int unsigned cycles = 0;

  function automatic h4_result_t mk_result(logic kind, logic [7:0] d, logic f, logic l,
                                           logic [1:0] st);
    h4_result_t r;
    r.kind    = kind;
    r.data    = d;
    r.first   = f;
    r.last    = l;
    r.status  = st;
    r.run_end = 1'b0;
    return r;
  endfunction

  // One received byte through the H4 parser; fills step_results.
  task automatic deframe_byte(input logic [7:0] b);
    int unsigned hsz;
    int unsigned plen;
    int unsigned k;
    logic        fin;
    step_results.delete();
    case (prs_phase)
      WAIT_TYPE: begin
        if (b == h4d_pkg::TYPE_EVENT) begin
          cur_acl   = 1'b0;
          prs_phase = EVT_HEADER;
          hdr_held  = 0;
        end else if (b == h4d_pkg::TYPE_ACL) begin
          cur_acl   = 1'b1;
          prs_phase = ACL_HEADER;
          hdr_held  = 0;
        end else begin
          step_results.push_back(mk_result(1'b0, b, 1'b0, 1'b0, h4d_pkg::ST_BAD_TYP));
        end
      end
      EVT_HEADER, ACL_HEADER: begin
        hsz = cur_acl ? h4d_pkg::ACL_HDR : h4d_pkg::EVT_HDR;
        if (hdr_held + 1 < hsz) begin
          // hold every header byte but the last
          hdr_bytes[hdr_held] = b;
          hdr_held++;
        end else begin
          hdr_held = 0;
          plen = cur_acl ? {b, hdr_bytes[2]} : b;
          if (plen + hsz > max_pkt_size) begin
            step_results.push_back(mk_result(cur_acl, b, 1'b0, 1'b0, h4d_pkg::ST_TOO_LNG));
            prs_phase = WAIT_TYPE;
          end else begin
            for (k = 0; k + 1 < hsz; k++)
              step_results.push_back(mk_result(cur_acl, hdr_bytes[k], k == 0, 1'b0,
                                               h4d_pkg::ST_DATA));
            step_results.push_back(mk_result(cur_acl, b, 1'b0, plen == 0, h4d_pkg::ST_DATA));
            if (plen == 0) begin
              prs_phase = WAIT_TYPE;
            end else begin
              payload_left = plen;
              prs_phase    = PAYLOAD;
            end
          end
        end
      end
      default: begin
        fin = payload_left <= 1;
        step_results.push_back(mk_result(cur_acl, b, 1'b0, fin, h4d_pkg::ST_DATA));
        if (fin) begin
          payload_left = 0;
          prs_phase    = WAIT_TYPE;
        end else begin
          payload_left--;
        end
      end
    endcase
    if (step_results.size() != 0)
      step_results[step_results.size() - 1].run_end = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Rx side: one transaction per call, optional idle burst in front
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input row_kind_e how, input h4_result_t typed);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
    deframe_byte(b);
    case (how)
      ROW_PRED: foreach (step_results[i]) deframed_q.push_back(step_results[i]);
      ROW_ONE:  deframed_q.push_back(typed);
      default:  ;
    endcase
  endtask

  // Register writes only with the block drained. A held header byte owes no
  // result, so leave a few cycles after the queue empties.
  task automatic set_max_packet(input logic [15:0] v);
    rx_if.valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    max_pkt_size  = v;
    cfg_writes++;
  endtask

  // One random packet, mostly well formed. Lengths stay small, sit on the
  // buffer limit, or are plainly too long so the run stays short.
  task automatic send_random_frame();
    int unsigned dice;
    int unsigned mode;
    int unsigned hsz;
    int unsigned max_ok;
    int unsigned fmax;
    int unsigned plen;
    logic        acl;
    logic [7:0]  b;
    // close out anything left open by a broken sequence
    while (prs_phase != WAIT_TYPE) send_byte(8'($urandom_range(0, 255)), ROW_PRED, '0);
    dice = $urandom_range(0, 19);
    if (dice < 2) begin
      do b = 8'($urandom_range(0, 255));
      while (b == h4d_pkg::TYPE_EVENT || b == h4d_pkg::TYPE_ACL);
      send_byte(b, ROW_PRED, '0);
    end else if (dice == 2) begin
      // a fresh type byte lands mid event header and is taken as a header byte
      send_byte(h4d_pkg::TYPE_EVENT, ROW_PRED, '0);
      send_byte($urandom_range(0, 1) ? h4d_pkg::TYPE_ACL : h4d_pkg::TYPE_EVENT, ROW_PRED, '0);
    end else begin
      acl    = 1'($urandom_range(0, 1));
      hsz    = acl ? h4d_pkg::ACL_HDR : h4d_pkg::EVT_HDR;
      fmax   = acl ? 32'hFFFF : 32'hFF;
      max_ok = max_pkt_size - hsz;
      mode   = $urandom_range(0, 9);
      plen   = $urandom_range(0, 4);
      if (mode >= 8 && max_ok < fmax)
        plen = $urandom_range(max_ok + 1, fmax);
      else if (mode >= 6 && max_ok <= 16)
        plen = max_ok + $urandom_range(0, 1);
      if (acl) begin
        send_byte(h4d_pkg::TYPE_ACL, ROW_PRED, '0);
        send_byte(8'($urandom_range(0, 255)), ROW_PRED, '0);
        send_byte(8'($urandom_range(0, 255)), ROW_PRED, '0);
        send_byte(8'(plen), ROW_PRED, '0);
        send_byte(8'(plen >> 8), ROW_PRED, '0);
      end else begin
        send_byte(h4d_pkg::TYPE_EVENT, ROW_PRED, '0);
        send_byte(8'($urandom_range(0, 255)), ROW_PRED, '0);
        send_byte(8'(plen), ROW_PRED, '0);
      end
      while (prs_phase == PAYLOAD) send_byte(8'($urandom_range(0, 255)), ROW_PRED, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: compare each transaction with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_result();
    h4_result_t got;
    h4_result_t want;
    got.kind    = res_if.packet_kind;
    got.data    = res_if.data_byte;
    got.first   = res_if.first_byte;
    got.last    = res_if.last_byte;
    got.status  = res_if.status;
    got.run_end = res_if.run_end;
    results_seen++;
    if (got.status == h4d_pkg::ST_BAD_TYP) bad_type_seen++;
    if (got.status == h4d_pkg::ST_TOO_LNG) too_long_seen++;
    if (got.last === 1'b1) pkts_closed++;
    if (deframed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected result: kind=%0d data=%02h first=%0d last=%0d st=%0d end=%0d",
                 $time, got.kind, got.data, got.first, got.last, got.status, got.run_end);
    end else begin
      want = deframed_q.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.first !== want.first ||
          got.last !== want.last || got.status !== want.status ||
          got.run_end !== want.run_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d: exp kind=%0d data=%02h first=%0d last=%0d st=%0d end=%0d",
                   $time, results_seen, want.kind, want.data, want.first, want.last,
                   want.status, want.run_end,
                   " | got kind=%0d data=%02h first=%0d last=%0d st=%0d end=%0d",
                   got.kind, got.data, got.first, got.last, got.status, got.run_end);
      end
    end
  endtask

  // Sink with random stall bursts
  initial begin : result_sink
    int unsigned stall_left;
    logic        rdy;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) check_result();
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        rdy        = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      res_if.ready <= rdy;
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: timeout after %0d cycles, %0d results still owed", cycles, deframed_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random phases at several buffer sizes
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned p;
    int unsigned phase_start;
    int unsigned n_directed;
    logic [15:0] phase_max;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[r]) begin
      if (dir_tbl[r].how == ROW_CFG)
        set_max_packet(dir_tbl[r].val);
      else
        send_byte(dir_tbl[r].val[7:0], dir_tbl[r].how, dir_tbl[r].res);
    end
    n_directed = bytes_sent;

    // each phase starts from a drained block; the last one runs without idling
    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       phase_max = 16'hFFFF;
        1:       phase_max = 16'd4;
        2:       phase_max = 16'd5;
        3:       phase_max = 16'($urandom_range(6, 24));
        4:       phase_max = h4d_pkg::MAX_PKT_RESET;
        default: phase_max = 16'($urandom_range(4, 300));
      endcase
      if (p == N_PHASES - 1) idle_en = 1'b0;
      set_max_packet(phase_max);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RAND_PER_PHASE) send_random_frame();
    end

    rx_if.valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("tb: %0d bytes sent (%0d directed), %0d buffer-size writes, %0d results checked",
             bytes_sent, n_directed, cfg_writes, results_seen);
    $display("tb: %0d packets closed, %0d bad-type drops, %0d over-length drops",
             pkts_closed, bad_type_seen, too_long_seen);
    if (mismatches == 0 && deframed_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
